### rtl/core/vdt_pkg.sv
package vdt_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int COORD_W     = 32;
   localparam int OWNER_W     = 16;
   localparam int VINDEX_W    = 10;

   typedef struct packed {
      logic signed [COORD_W-1:0] coord_x;
      logic signed [COORD_W-1:0] coord_y;
      logic signed [COORD_W-1:0] coord_z;
      logic [OWNER_W-1:0]        owner_quad;
   } req_type;

   typedef struct packed {
      logic [VINDEX_W-1:0] vertex_index;
      logic                was_new;
      logic                table_full;
   } rsp_type;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] z;
      logic [OWNER_W-1:0] owner;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      entry_type        wr_data;
      logic [IDX_W-1:0] rd_addr;
   } mem_cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

endpackage

### rtl/core/vdt_ram.sv
module vdt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/vdt_ctrl.sv
module vdt_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  vdt_pkg::req_type    req_data,
   output logic                rsp_valid,
   output vdt_pkg::rsp_type    rsp_data,
   output vdt_pkg::mem_cmd_type mem_cmd,
   input  vdt_pkg::entry_type  mem_rd_data
);
   import vdt_pkg::*;

   state_type        state_ff, state_in;
   req_type          req_ff, req_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] data_idx_ff, data_idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic             accept;
   logic             hit;
   logic             last;
   logic             finish;
   logic [CNT_W-1:0] next_idx;

   assign accept   = start && (state_ff == ST_IDLE);
   assign busy     = (state_ff != ST_IDLE);
   assign next_idx = CNT_W'(data_idx_ff) + CNT_W'(1);
   assign last     = (next_idx == count_ff);

   // The entry read in the previous cycle is compared against the held request.
   assign hit = (mem_rd_data.x == req_ff.coord_x) &&
                (mem_rd_data.y == req_ff.coord_y) &&
                (mem_rd_data.z == req_ff.coord_z);

   // An empty table needs no scan, so it finishes in the cycle of the transfer.
   assign finish = (accept && (count_ff == '0)) ||
                   ((state_ff == ST_SCAN) && !hit && last);

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      count_in     = count_ff;
      data_idx_in  = data_idx_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      mem_cmd      = '0;

      case (state_ff)
         ST_IDLE: begin
            mem_cmd.rd_addr = '0;
            if (accept) begin
               req_in      = req_data;
               data_idx_in = '0;
               if (count_ff != '0) begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            mem_cmd.rd_addr = next_idx[IDX_W-1:0];
            data_idx_in     = next_idx[IDX_W-1:0];
            if (hit) begin
               state_in            = ST_IDLE;
               rsp_valid_in        = 1'b1;
               rsp_in.vertex_index = VINDEX_W'(data_idx_ff);
               rsp_in.was_new      = 1'b0;
               rsp_in.table_full   = 1'b0;
            end else if (last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (finish) begin
         rsp_valid_in = 1'b1;
         if (count_ff == CNT_W'(TABLE_DEPTH)) begin
            rsp_in.vertex_index = '0;
            rsp_in.was_new      = 1'b0;
            rsp_in.table_full   = 1'b1;
         end else begin
            mem_cmd.wr_en       = 1'b1;
            mem_cmd.wr_addr     = count_ff[IDX_W-1:0];
            rsp_in.vertex_index = VINDEX_W'(count_ff);
            rsp_in.was_new      = 1'b1;
            rsp_in.table_full   = 1'b0;
            count_in            = count_ff + CNT_W'(1);
         end
      end

      // The request register holds the payload by the time a scan finishes;
      // on an empty table the payload comes straight from the ports.
      if (accept) begin
         mem_cmd.wr_data.x     = req_data.coord_x;
         mem_cmd.wr_data.y     = req_data.coord_y;
         mem_cmd.wr_data.z     = req_data.coord_z;
         mem_cmd.wr_data.owner = req_data.owner_quad;
      end else begin
         mem_cmd.wr_data.x     = req_ff.coord_x;
         mem_cmd.wr_data.y     = req_ff.coord_y;
         mem_cmd.wr_data.z     = req_ff.coord_z;
         mem_cmd.wr_data.owner = req_ff.owner_quad;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff      <= req_in;
      data_idx_ff <= data_idx_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### rtl/core/vertex_dedup_table.sv
// Vertex deduplication table.
// A vertex (three Q16.16 coordinates plus its owner quad) is transferred on
// req_data when start is high and busy is low. The block scans the stored
// vertices from index 0 upward, one entry per cycle out of a single table
// memory with a registered read, and stops at the first entry that matches
// on all three coordinates. Without a match the vertex is appended at the
// next free index, or table_full is flagged when all entries are in use.
// Exactly one result per transfer appears on rsp_data for one cycle, marked
// by rsp_valid; the receiver cannot stall it and must take it in that cycle.
// The result is registered: a match at index j is reported after entry j is
// read and compared, an append or full result after the last stored entry is
// compared without a match, or after the transfer itself on an empty table.
// The memory read port sets the rate of one entry per cycle. busy drops in
// the cycle that shows the result, and a new transfer may be taken then.
// Reset empties the table by clearing the entry count; the memory itself is
// not cleared, since only entries below the count are ever compared.
module vertex_dedup_table (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  vdt_pkg::req_type req_data,
   output logic             rsp_valid,
   output vdt_pkg::rsp_type rsp_data
);
   import vdt_pkg::*;

   mem_cmd_type mem_cmd;
   entry_type   mem_rd_data;

   vdt_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .mem_cmd     (mem_cmd),
      .mem_rd_data (mem_rd_data)
   );

   vdt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_cmd.wr_en),
      .wr_addr (mem_cmd.wr_addr),
      .wr_data (mem_cmd.wr_data),
      .rd_addr (mem_cmd.rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule

### rtl/core/vdt_checker.sv
module vdt_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_valid,
   input vdt_pkg::rsp_type rsp_data
);
   import vdt_pkg::*;

   // Every transfer either keeps the block busy or answers at once.
   a_accept_then_work: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("transfer neither started a scan nor produced a result");

   a_result_frees: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while still busy");

   a_single_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("two results in consecutive cycles");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.was_new && rsp_data.table_full))
      else $error("new entry and full flag both set");

   a_full_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.table_full) |-> (rsp_data.vertex_index == '0))
      else $error("full result carries a nonzero index");

endmodule

bind vertex_dedup_table vdt_checker u_vdt_checker (.*);
